FILE: rtl/core/oate_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array table engine package
// Shared widths, operation codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package oate_pkg;

   localparam int OP_BITS           = 3;
   localparam int POS_BITS          = 7;
   localparam int DATA_BITS         = 32;
   localparam int MASK_BITS         = 64;
   localparam int MINPOS_BITS       = 6;
   localparam int COUNT_BITS        = 7;
   localparam int DEFAULT_DEPTH     = 64;
   localparam int DEFAULT_WORD_BITS = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT    = 3'd0,
      OP_DELETE    = 3'd1,
      OP_READ      = 3'd2,
      OP_OVERWRITE = 3'd3,
      OP_SEARCH    = 3'd4,
      OP_ARGMIN    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ISSUE,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic issue;
      logic final_write;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic left_zero;
      logic left_last;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/oate_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oate_ram #(
   parameter  int WIDTH     = 32,
   parameter  int DEPTH     = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/oate_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered array table engine controller
// Sequences capture, setup, the memory walk, the final write and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module oate_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  oate_pkg::status_type status,
   output oate_pkg::cmd_type    cmd
);

   oate_pkg::state_type state_ff;
   oate_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oate_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         oate_pkg::ST_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
            if (req_valid) begin
               state_in = oate_pkg::ST_SETUP;
            end
         end
         oate_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = oate_pkg::ST_ISSUE;
         end
         oate_pkg::ST_ISSUE: begin
            cmd.issue = !status.left_zero;
            if (status.left_zero || status.left_last) begin
               state_in = oate_pkg::ST_DRAIN;
            end
         end
         oate_pkg::ST_DRAIN: begin
            state_in = oate_pkg::ST_WRITE;
         end
         oate_pkg::ST_WRITE: begin
            cmd.final_write = 1'b1;
            state_in        = oate_pkg::ST_DONE;
         end
         oate_pkg::ST_DONE: begin
            cmd.respond = status.out_free;
            if (status.out_free) begin
               state_in = oate_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = oate_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/oate_dp.sv
// ----------------------------------------------------------------------------
// Ordered array table engine datapath
// Request registers, live count, entry memory, walk counters, the
// search and minimum accumulators and the output register.
// ----------------------------------------------------------------------------
module oate_dp #(
   parameter  int DEPTH     = oate_pkg::DEFAULT_DEPTH,
   parameter  int WORD_BITS = oate_pkg::DEFAULT_WORD_BITS,
   localparam int IDX_W     = $clog2(DEPTH),
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  oate_pkg::cmd_type                   cmd,
   output oate_pkg::status_type                status,
   input  logic [oate_pkg::OP_BITS-1:0]        req_op,
   input  logic [oate_pkg::POS_BITS-1:0]       req_position,
   input  logic signed [oate_pkg::DATA_BITS-1:0] req_item_value,
   input  logic [oate_pkg::MASK_BITS-1:0]      req_visited_mask,
   input  logic [oate_pkg::POS_BITS-1:0]       req_excluded_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [oate_pkg::DATA_BITS-1:0] rsp_read_word,
   output logic                                rsp_found,
   output logic [oate_pkg::MINPOS_BITS-1:0]    rsp_min_position,
   output logic [oate_pkg::COUNT_BITS-1:0]     rsp_entry_count,
   output logic                                rsp_error
);

   localparam logic [oate_pkg::COUNT_BITS-1:0] DEPTH_C = oate_pkg::COUNT_BITS'(DEPTH);

   logic [oate_pkg::OP_BITS-1:0]   op_ff;
   logic [oate_pkg::POS_BITS-1:0]  pos_ff;
   logic [WORD_BITS-1:0]           val_ff;
   logic [DEPTH-1:0]               mask_ff;
   logic [oate_pkg::POS_BITS-1:0]  excl_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;
   logic                           err_ff;
   logic                           err_in;
   logic [CNT_W-1:0]               left_ff;
   logic [CNT_W-1:0]               left_in;
   logic [IDX_W-1:0]               idx_ff;
   logic [IDX_W-1:0]               idx_in;
   logic                           rv_ff;
   logic [IDX_W-1:0]               ridx_ff;
   logic                           found_ff;
   logic [IDX_W-1:0]               minpos_ff;
   logic [WORD_BITS-1:0]           best_ff;
   logic [WORD_BITS-1:0]           word_ff;
   logic                           rsp_valid_ff;

   logic [WORD_BITS+31:0]          val_ext;
   logic [WORD_BITS+31:0]          word_sx;
   logic [oate_pkg::COUNT_BITS-1:0] cnt7;
   logic                           in_range;
   logic                           is_insert;
   logic                           is_delete;
   logic                           is_read;
   logic                           is_search;
   logic                           is_argmin;
   logic                           is_overwrite;
   logic [WORD_BITS-1:0]           rd_data;
   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic [WORD_BITS-1:0]           wr_data;
   logic                           eligible;

   assign val_ext  = {{WORD_BITS{1'b0}}, req_item_value};
   assign word_sx  = {{32{word_ff[WORD_BITS-1]}}, word_ff};
   assign cnt7     = oate_pkg::COUNT_BITS'(count_ff);
   assign in_range = pos_ff < cnt7;

   always_comb begin
      is_insert    = 1'b0;
      is_delete    = 1'b0;
      is_read      = 1'b0;
      is_overwrite = 1'b0;
      is_search    = 1'b0;
      is_argmin    = 1'b0;
      err_in       = 1'b0;
      left_in      = '0;
      idx_in       = '0;
      unique case (op_ff)
         oate_pkg::OP_INSERT: begin
            is_insert = 1'b1;
            err_in    = (cnt7 >= DEPTH_C) || (pos_ff > cnt7);
            left_in   = err_in ? '0 : CNT_W'(cnt7 - pos_ff);
            idx_in    = IDX_W'(cnt7 - 7'd1);
         end
         oate_pkg::OP_DELETE: begin
            is_delete = 1'b1;
            err_in    = !in_range;
            left_in   = err_in ? '0 : CNT_W'(cnt7 - pos_ff - 7'd1);
            idx_in    = IDX_W'(pos_ff + 7'd1);
         end
         oate_pkg::OP_READ: begin
            is_read = 1'b1;
            left_in = in_range ? CNT_W'(1) : '0;
            idx_in  = IDX_W'(pos_ff);
         end
         oate_pkg::OP_OVERWRITE: begin
            is_overwrite = 1'b1;
         end
         oate_pkg::OP_SEARCH: begin
            is_search = 1'b1;
            left_in   = count_ff;
         end
         oate_pkg::OP_ARGMIN: begin
            is_argmin = 1'b1;
            left_in   = count_ff;
         end
         default: begin
            err_in = 1'b1;
         end
      endcase
   end

   // Each returned entry is moved one place up for insert and one place down for delete.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[IDX_W-1:0];
      wr_data = val_ff;
      if (rv_ff && is_insert) begin
         wr_en   = 1'b1;
         wr_addr = ridx_ff + IDX_W'(1);
         wr_data = rd_data;
      end else if (rv_ff && is_delete) begin
         wr_en   = 1'b1;
         wr_addr = ridx_ff - IDX_W'(1);
         wr_data = rd_data;
      end else if (cmd.final_write) begin
         wr_en = (is_insert && !err_ff) || (is_overwrite && in_range);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.final_write && !err_ff && is_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.final_write && !err_ff && is_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign eligible = !mask_ff[ridx_ff] &&
                     (excl_ff != oate_pkg::POS_BITS'(ridx_ff)) &&
                     (!found_ff || ($signed(rd_data) < $signed(best_ff)));

   oate_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         pos_ff  <= req_position;
         val_ff  <= val_ext[WORD_BITS-1:0];
         mask_ff <= req_visited_mask[DEPTH-1:0];
         excl_ff <= req_excluded_index;
      end
      if (cmd.setup) begin
         err_ff    <= err_in;
         idx_ff    <= idx_in;
         found_ff  <= 1'b0;
         minpos_ff <= '0;
         best_ff   <= '0;
         word_ff   <= '0;
      end else begin
         if (cmd.issue) begin
            idx_ff <= is_insert ? idx_ff - IDX_W'(1) : idx_ff + IDX_W'(1);
         end
         if (rv_ff && is_read) begin
            word_ff <= rd_data;
         end
         if (rv_ff && is_search && (rd_data == val_ff)) begin
            found_ff <= 1'b1;
         end
         if (rv_ff && is_argmin && eligible) begin
            found_ff  <= 1'b1;
            minpos_ff <= ridx_ff;
            best_ff   <= rd_data;
         end
      end
      ridx_ff <= idx_ff;
      if (cmd.respond) begin
         rsp_read_word    <= word_sx[31:0];
         rsp_found        <= found_ff;
         rsp_min_position <= oate_pkg::MINPOS_BITS'(minpos_ff);
         rsp_entry_count  <= cnt7;
         rsp_error        <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         left_ff      <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rv_ff    <= cmd.issue;
         if (cmd.setup) begin
            left_ff <= left_in;
         end else if (cmd.issue) begin
            left_ff <= left_ff - CNT_W'(1);
         end
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.left_zero = (left_ff == '0);
   assign status.left_last = (left_ff == CNT_W'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/core/ordered_array_table_engine.sv
// ----------------------------------------------------------------------------
// Ordered array table engine
// Ordered list of up to DEPTH signed words with insert, delete, read,
// overwrite, search and masked minimum search.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the req_ channel carries one operation.
// Exactly one response transaction on the rsp_ channel follows, in order.
// A request is taken only while the engine is idle. Each operation walks
// the entry memory one entry per cycle through its single read port:
// insert moves count - position entries, delete count - position - 1,
// search and the minimum search read all live entries, read takes one if
// its position is in range, and overwrite and failed inserts or deletes none.
// The response sits in an output register; the engine accepts the next
// request while a response still waits. If the receiver stalls, a second
// finished result waits in the engine until the output register frees.
// Reset empties the list and drops any pending response; no clearing pass
// is needed since only entries below the live count are ever read.
// ----------------------------------------------------------------------------
module ordered_array_table_engine #(
   parameter int DEPTH     = oate_pkg::DEFAULT_DEPTH,
   parameter int WORD_BITS = oate_pkg::DEFAULT_WORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [oate_pkg::OP_BITS-1:0]          req_op,
   input  logic [oate_pkg::POS_BITS-1:0]         req_position,
   input  logic signed [oate_pkg::DATA_BITS-1:0] req_item_value,
   input  logic [oate_pkg::MASK_BITS-1:0]        req_visited_mask,
   input  logic [oate_pkg::POS_BITS-1:0]         req_excluded_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [oate_pkg::DATA_BITS-1:0] rsp_read_word,
   output logic                                  rsp_found,
   output logic [oate_pkg::MINPOS_BITS-1:0]      rsp_min_position,
   output logic [oate_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   output logic                                  rsp_error
);

   oate_pkg::cmd_type    cmd;
   oate_pkg::status_type status;

   oate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   oate_dp #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .req_visited_mask   (req_visited_mask),
      .req_excluded_index (req_excluded_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_word      (rsp_read_word),
      .rsp_found          (rsp_found),
      .rsp_min_position   (rsp_min_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_error          (rsp_error)
   );

endmodule
